// ===== sv/legendre_series_eval_2d_macros.svh =====
// Assertion macros shared by the checker of the bivariate Legendre series evaluator
`ifndef LEGENDRE_SERIES_EVAL_2D_MACROS_SVH
`define LEGENDRE_SERIES_EVAL_2D_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define LSE2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define LSE2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/lse2d_pkg.sv =====
// Types and constants of the bivariate Legendre series evaluator
`default_nettype none

package lse2d_pkg;

  // Input item codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Sequencer states
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_P0   = 13'b0000000000010,
    S_P1   = 13'b0000000000100,
    S_M1   = 13'b0000000001000,
    S_M2   = 13'b0000000010000,
    S_M3   = 13'b0000000100000,
    S_SUB  = 13'b0000001000000,
    S_M4   = 13'b0000010000000,
    S_WR   = 13'b0000100000000,
    S_TSET = 13'b0001000000000,
    S_TA   = 13'b0010000000000,
    S_TB   = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  // Fixed-point constants
  localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;
  localparam logic signed [15:0] COORD_ONE = 16'sd16384;
  localparam logic signed [39:0] OUT_MAX   = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] OUT_MIN   = 40'sh80_0000_0000;
  localparam logic [13:0] HALF14 = 14'h2000;
  localparam logic [23:0] HALF24 = 24'h80_0000;
  localparam logic [29:0] HALF30 = 30'h2000_0000;

  // round(2^24 / k), half up, for k = 0..32 (k = 0 unused)
  localparam int RECIP_IW = 6;
  localparam logic [24:0] RECIP_TAB [33] = '{
    25'd0,       25'd16777216, 25'd8388608, 25'd5592405, 25'd4194304,
    25'd3355443, 25'd2796203,  25'd2396745, 25'd2097152, 25'd1864135,
    25'd1677722, 25'd1525201,  25'd1398101, 25'd1290555, 25'd1198373,
    25'd1118481, 25'd1048576,  25'd986895,  25'd932068,  25'd883011,
    25'd838861,  25'd798915,   25'd762601,  25'd729444,  25'd699051,
    25'd671089,  25'd645278,   25'd621378,  25'd599186,  25'd578525,
    25'd559241,  25'd541201,   25'd524288
  };

endpackage

`default_nettype wire

// ===== sv/legendre_series_eval_2d.sv =====
// Bivariate Legendre series evaluator: coefficient store, polynomial store, shared multiplier
// A load item is taken while idle and leaves busy low. An evaluate item keeps busy high
// while it builds Px and Py by recurrence and walks the terms through one shared multiplier:
// each recurrence step runs states M1, M2, M3, SUB, M4 and WR, and each series term takes
// two products. The result strobe rises in the first cycle busy is low.
// Synchronous active-low reset clears control and sets terms_per_axis to 1; the stores keep
// their contents and are not cleared.
`default_nettype none

module legendre_series_eval_2d #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input items
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_func,
  input  wire logic [7:0]         in_coef_index,
  input  wire logic signed [31:0] in_coef_value,
  input  wire logic signed [15:0] in_x_coord,
  input  wire logic signed [15:0] in_y_coord,
  // results
  output logic                    out_valid,
  output logic signed [39:0]      out_series_value,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data
);

  import lse2d_pkg::*;

  localparam int CD   = MAX_TERMS * (MAX_TERMS + 1) / 2;
  localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
  localparam int PD   = 2 * MAX_TERMS;
  localparam int PAW  = $clog2(PD);
  localparam int IW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int MW   = $clog2(MAX_TERMS + 1);
  localparam int CW   = MW + 1;
  localparam int N30W = 31 + $clog2(3 * MAX_TERMS);
  localparam int NUMW = N30W + 14;
  localparam int MBW  = 33;
  localparam int PRW  = N30W + MBW;
  localparam int AW   = 34 + $clog2(CD + 1);
  localparam int SW   = (AW > 41) ? AW + 1 : 42;

  // control registers
  state_t             state_r, state_nxt;
  logic               axis_r, axis_nxt;
  logic               live_r, live_nxt;
  logic               pp_v_r, pp_v_nxt;
  logic               cpp_v_r, cpp_v_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [4:0]         terms_r;
  logic [MW-1:0]      m_r, m_nxt;

  // datapath registers
  logic signed [15:0]     x_r, x_nxt, y_r, y_nxt;
  logic [IW-1:0]          n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CAW-1:0]         k_r, k_nxt;
  logic signed [31:0]     p_r, p_nxt, pm1_r, pm1_nxt;
  logic signed [NUMW-1:0] t_r, t_nxt;
  logic signed [N30W-1:0] num30_r, num30_nxt;
  logic signed [PRW-1:0]  prod_r, prod_nxt;
  logic signed [31:0]     pp_r, pp_nxt, c_a_r, c_a_nxt, c_b_r, c_b_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic signed [39:0]     out_value_r, out_value_nxt;

  // memory ports
  logic signed [31:0] pmem [PD];
  logic signed [31:0] cmem [CD];
  logic signed [31:0] px_rd_r, py_rd_r, coef_rd_r;
  logic               pm_we, rd_en, cm_we;
  logic [IW-1:0]      pm_widx, rd_i, rd_j;
  logic [PAW-1:0]     pm_waddr;
  logic signed [31:0] pm_wdata;
  logic [CAW-1:0]     rd_k;

  // shared multiplier
  logic signed [N30W-1:0] mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [PRW-1:0]  mul_p;
  logic                   mul_en;

  // misc datapath
  logic                   in_acc;
  logic signed [15:0]     coord;
  logic [MW-1:0]          m_cap;
  logic [PRW:0]           r30_sum, r24_sum;
  logic signed [PRW-30:0] r30;
  logic signed [PRW-24:0] r24;
  logic signed [31:0]     pp_w, p_new;
  logic signed [32:0]     term33;
  logic [NUMW:0]          num_sum;
  logic signed [SW-1:0]   fin_sum;
  logic                   row_end, last_term;
  logic [IW-1:0]          i_adv, j_adv;
  state_t                 after_axis;

  function automatic logic signed [15:0] clamp_coord(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v > COORD_ONE) r = COORD_ONE;
    else if (v < -COORD_ONE) r = -COORD_ONE;
    else r = v;
    return r;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign in_acc    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_series_value = out_value_r;

  assign coord = axis_r ? y_r : x_r;
  assign m_cap = (int'(terms_r) > MAX_TERMS) ? MW'(MAX_TERMS) : MW'(terms_r);

  // round half up by 2^30 (term products) and by 2^24 (recurrence)
  assign r30_sum = (PRW+1)'(prod_r) + (PRW+1)'(HALF30);
  assign r30     = $signed(r30_sum[PRW:30]);
  assign pp_w    = r30[31:0];
  assign term33  = r30[32:0];
  assign r24_sum = (PRW+1)'(prod_r) + (PRW+1)'(HALF24);
  assign r24     = $signed(r24_sum[PRW:24]);

  // clamp of a new polynomial value to [-1, 1]
  always_comb begin
    if (r24 > (PRW-23)'(ONE_Q30)) p_new = ONE_Q30;
    else if (r24 < -(PRW-23)'(ONE_Q30)) p_new = -ONE_Q30;
    else p_new = 32'(r24);
  end

  // recurrence numerator: x-term minus n*P(n-1)*2^14, rounded to Q.30
  assign num_sum = (NUMW+1)'(t_r)
                 - ((NUMW+1)'($signed(prod_r[N30W-1:0])) << 14)
                 + (NUMW+1)'(HALF14);

  // final sum with saturation to the output range
  assign fin_sum = SW'(acc_r) + (cpp_v_r ? SW'(term33) : SW'(0));

  // walk of the triangular term order
  assign row_end   = (CW'(i_r) + CW'(j_r) + CW'(1)) >= CW'(m_r);
  assign last_term = row_end && ((CW'(i_r) + CW'(1)) >= CW'(m_r));
  assign i_adv     = row_end ? i_r + 1'b1 : i_r;
  assign j_adv     = row_end ? '0 : j_r + 1'b1;

  assign after_axis = axis_r ? S_TSET : S_P0;

  assign mul_p    = mul_a * mul_b;
  assign prod_nxt = mul_en ? mul_p : prod_r;

  assign cm_we    = in_acc && (in_func == FUNC_LOAD) && (int'(in_coef_index) < CD);
  assign pm_waddr = (axis_r ? PAW'(MAX_TERMS) : PAW'(0)) + PAW'(pm_widx);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    live_nxt      = live_r;
    pp_v_nxt      = pp_v_r;
    cpp_v_nxt     = cpp_v_r;
    out_valid_nxt = 1'b0;
    m_nxt         = m_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    pm1_nxt       = pm1_r;
    t_nxt         = t_r;
    num30_nxt     = num30_r;
    pp_nxt        = pp_r;
    c_a_nxt       = c_a_r;
    c_b_nxt       = c_b_r;
    acc_nxt       = acc_r;
    out_value_nxt = out_value_r;
    pm_we         = 1'b0;
    pm_widx       = '0;
    pm_wdata      = ONE_Q30;
    rd_en         = 1'b0;
    rd_i          = '0;
    rd_j          = '0;
    rd_k          = '0;
    mul_a         = '0;
    mul_b         = '0;
    mul_en        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_func == FUNC_EVAL)) begin
          x_nxt     = clamp_coord(in_x_coord);
          y_nxt     = clamp_coord(in_y_coord);
          m_nxt     = m_cap;
          axis_nxt  = 1'b0;
          acc_nxt   = '0;
          cpp_v_nxt = 1'b0;
          state_nxt = (m_cap == '0) ? S_FIN : S_P0;
        end
      end
      // P0 = 1, P1 = x
      S_P0: begin
        pm_we    = 1'b1;
        pm_widx  = '0;
        pm_wdata = ONE_Q30;
        pm1_nxt  = ONE_Q30;
        p_nxt    = {coord, 16'd0};
        if (CW'(m_r) > CW'(1)) begin
          state_nxt = S_P1;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = after_axis;
        end
      end
      S_P1: begin
        pm_we    = 1'b1;
        pm_widx  = IW'(1);
        pm_wdata = p_r;
        n_nxt    = IW'(1);
        if (CW'(m_r) > CW'(2)) begin
          state_nxt = S_M1;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = after_axis;
        end
      end
      // (2n+1) * x
      S_M1: begin
        mul_a     = N30W'(coord);
        mul_b     = MBW'({n_r, 1'b1});
        mul_en    = 1'b1;
        state_nxt = S_M2;
      end
      // (2n+1) * x * P(n)
      S_M2: begin
        mul_a     = N30W'(p_r);
        mul_b     = MBW'(prod_r);
        mul_en    = 1'b1;
        state_nxt = S_M3;
      end
      // n * P(n-1)
      S_M3: begin
        t_nxt     = prod_r[NUMW-1:0];
        mul_a     = N30W'(pm1_r);
        mul_b     = MBW'(n_r);
        mul_en    = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        num30_nxt = $signed(num_sum[NUMW-1:14]);
        state_nxt = S_M4;
      end
      // divide by n+1 through the reciprocal table
      S_M4: begin
        mul_a     = num30_r;
        mul_b     = MBW'(RECIP_TAB[RECIP_IW'(n_r) + RECIP_IW'(1)]);
        mul_en    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        pm_we    = 1'b1;
        pm_widx  = n_r + 1'b1;
        pm_wdata = p_new;
        pm1_nxt  = p_r;
        p_nxt    = p_new;
        n_nxt    = n_r + 1'b1;
        if ((CW'(n_r) + CW'(2)) < CW'(m_r)) begin
          state_nxt = S_M1;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = after_axis;
        end
      end
      // first term read
      S_TSET: begin
        rd_en     = 1'b1;
        i_nxt     = '0;
        j_nxt     = '0;
        k_nxt     = '0;
        live_nxt  = 1'b1;
        pp_v_nxt  = 1'b0;
        cpp_v_nxt = 1'b0;
        acc_nxt   = '0;
        state_nxt = S_TA;
      end
      // Px(i)*Py(j) for the current term, accumulate the term two back
      S_TA: begin
        if (live_r) begin
          mul_a   = N30W'(px_rd_r);
          mul_b   = MBW'(py_rd_r);
          mul_en  = 1'b1;
          c_a_nxt = coef_rd_r;
        end
        c_b_nxt = c_a_r;
        if (cpp_v_r) acc_nxt = acc_r + AW'(term33);
        state_nxt = S_TB;
      end
      // round the product, coefficient times previous product, next read
      S_TB: begin
        pp_nxt = pp_w;
        if (pp_v_r) begin
          mul_a  = N30W'(c_b_r);
          mul_b  = MBW'(pp_r);
          mul_en = 1'b1;
        end
        cpp_v_nxt = pp_v_r;
        pp_v_nxt  = live_r;
        if (live_r) begin
          if (last_term) begin
            live_nxt = 1'b0;
          end else begin
            i_nxt = i_adv;
            j_nxt = j_adv;
            k_nxt = k_r + 1'b1;
            rd_en = 1'b1;
            rd_i  = i_adv;
            rd_j  = j_adv;
            rd_k  = k_r + 1'b1;
          end
        end
        state_nxt = live_r ? S_TA : S_FIN;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        if (fin_sum > SW'(OUT_MAX)) out_value_nxt = OUT_MAX;
        else if (fin_sum < SW'(OUT_MIN)) out_value_nxt = OUT_MIN;
        else out_value_nxt = 40'(fin_sum);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      live_r      <= 1'b0;
      pp_v_r      <= 1'b0;
      cpp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      m_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      live_r      <= live_nxt;
      pp_v_r      <= pp_v_nxt;
      cpp_v_r     <= cpp_v_nxt;
      out_valid_r <= out_valid_nxt;
      m_r         <= m_nxt;
    end
  end

  // terms_per_axis register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terms_r <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      terms_r <= cfg_data;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    p_r         <= p_nxt;
    pm1_r       <= pm1_nxt;
    t_r         <= t_nxt;
    num30_r     <= num30_nxt;
    prod_r      <= prod_nxt;
    pp_r        <= pp_nxt;
    c_a_r       <= c_a_nxt;
    c_b_r       <= c_b_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

  // polynomial store: Px at 0.., Py at MAX_TERMS..; written while building, read after
  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= pm_wdata;
    if (rd_en) begin
      px_rd_r <= pmem[PAW'(rd_i)];
      py_rd_r <= pmem[PAW'(MAX_TERMS) + PAW'(rd_j)];
    end
  end

  // coefficient store: loads only while idle, so no read can meet a pending write
  always_ff @(posedge clk) begin
    if (cm_we) cmem[CAW'(in_coef_index)] <= in_coef_value;
    if (rd_en) coef_rd_r <= cmem[rd_k];
  end

endmodule

`default_nettype wire

// ===== sv/lse2d_checker.sv =====
// Port-level checker for the bivariate Legendre series evaluator, with its bind
`default_nettype none
`include "legendre_series_eval_2d_macros.svh"

module lse2d_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_func,
  input wire logic out_valid,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);

  import lse2d_pkg::*;

  logic load_acc, eval_acc;

  assign load_acc = start && !busy && (in_func == FUNC_LOAD);
  assign eval_acc = start && !busy && (in_func == FUNC_EVAL);

  // result strobe lasts one cycle
  `LSE2D_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held")
  // a load completes at once and never causes a result
  `LSE2D_ASSERT_NEXT(a_load_idle, load_acc, !busy && !out_valid, "load left block busy")
  // an evaluate holds the block busy before its result
  `LSE2D_ASSERT_NEXT(a_eval_busy, eval_acc, busy && !out_valid, "evaluate not busy")
  // a result ends an evaluation
  `LSE2D_ASSERT_NOW(a_strobe_end, $rose(out_valid), $past(busy) && !busy,
                    "result outside evaluation end")
  // user must send configuration only while idle; block does not enforce it
  `LSE2D_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !busy, "configuration while busy")

endmodule

bind legendre_series_eval_2d lse2d_checker u_lse2d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_func   (in_func),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
